FILE: src/rnd_pkg.sv
package rnd_pkg;

  localparam int DefaultWidth = 16;
  localparam int CntW = 5;

  typedef enum logic {
    METHOD_RESTORING    = 1'b0,
    METHOD_NONRESTORING = 1'b1
  } method_e;

  // per-item control that travels down the row next to the data
  typedef struct packed {
    method_e             method;
    logic                ovf;
    logic [CntW-1:0]     na;
    logic [CntW-1:0]     ns;
  } rnd_ctl_t;

endpackage

FILE: src/rnd_cell.sv
module rnd_cell
  import rnd_pkg::*;
#(
  parameter int WIDTH = DefaultWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  rnd_ctl_t         ctl_i,
  input  logic [WIDTH+1:0] p_i,
  input  logic [WIDTH-1:0] q_i,
  input  logic [WIDTH-1:0] b_i,
  output logic             valid_o,
  input  logic             ready_i,
  output rnd_ctl_t         ctl_o,
  output logic [WIDTH+1:0] p_o,
  output logic [WIDTH-1:0] q_o,
  output logic [WIDTH-1:0] b_o
);

  logic             valid_q;
  rnd_ctl_t         ctl_q, ctl_d;
  logic [WIDTH+1:0] p_q, p_d;
  logic [WIDTH-1:0] q_q, q_d;
  logic [WIDTH-1:0] b_q;
  logic [WIDTH+1:0] sh, bx, diff, sum;

  // partial remainder shifted left, next dividend bit brought in
  assign sh   = {p_i[WIDTH:0], q_i[WIDTH-1]};
  assign bx   = {2'b00, b_i};
  assign diff = sh - bx;
  assign sum  = sh + bx;

  always_comb begin
    ctl_d = ctl_i;
    p_d   = p_i;
    q_d   = q_i;
    if (!ctl_i.ovf) begin
      q_d = {q_i[WIDTH-2:0], 1'b0};
      if (ctl_i.method == METHOD_RESTORING) begin
        ctl_d.ns = ctl_i.ns + CntW'(1);
        if (diff[WIDTH+1]) begin
          // negative trial difference: keep the shifted value, count a restore
          p_d      = sh;
          ctl_d.na = ctl_i.na + CntW'(1);
        end else begin
          p_d    = diff;
          q_d[0] = 1'b1;
        end
      end else begin
        if (!p_i[WIDTH+1]) begin
          p_d      = diff;
          ctl_d.ns = ctl_i.ns + CntW'(1);
        end else begin
          p_d      = sum;
          ctl_d.na = ctl_i.na + CntW'(1);
        end
        q_d[0] = ~p_d[WIDTH+1];
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      ctl_q <= ctl_d;
      p_q   <= p_d;
      q_q   <= q_d;
      b_q   <= b_i;
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign p_o     = p_q;
  assign q_o     = q_q;
  assign b_o     = b_q;

endmodule

FILE: src/rnd_out.sv
module rnd_out
  import rnd_pkg::*;
#(
  parameter int WIDTH = DefaultWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  rnd_ctl_t         ctl_i,
  input  logic [WIDTH+1:0] p_i,
  input  logic [WIDTH-1:0] q_i,
  input  logic [WIDTH-1:0] b_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] quotient_o,
  output logic [WIDTH-1:0] remainder_o,
  output logic             overflow_o,
  output logic [CntW-1:0]  add_count_o,
  output logic [CntW-1:0]  sub_count_o,
  output logic [CntW-1:0]  iteration_count_o
);

  logic             valid_q;
  logic [WIDTH-1:0] quo_d, quo_q, rem_d, rem_q;
  logic [CntW-1:0]  na_d, na_q, ns_d, ns_q, it_d, it_q;
  logic             ovf_q;
  logic [WIDTH+1:0] fixed;

  assign fixed = p_i + {2'b00, b_i};

  always_comb begin
    quo_d = q_i;
    rem_d = p_i[WIDTH-1:0];
    na_d  = ctl_i.na;
    ns_d  = ctl_i.ns;
    it_d  = CntW'(WIDTH);
    // non-restoring ends on a negative remainder: add the divisor back once
    if (ctl_i.method == METHOD_NONRESTORING && p_i[WIDTH+1]) begin
      rem_d = fixed[WIDTH-1:0];
      na_d  = ctl_i.na + CntW'(1);
    end
    if (ctl_i.ovf) begin
      quo_d = '0;
      rem_d = '0;
      na_d  = '0;
      ns_d  = '0;
      it_d  = '0;
    end
  end

  assign ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
      ovf_q <= ctl_i.ovf;
      na_q  <= na_d;
      ns_q  <= ns_d;
      it_q  <= it_d;
    end
  end

  assign out_valid_o       = valid_q;
  assign quotient_o        = quo_q;
  assign remainder_o       = rem_q;
  assign overflow_o        = ovf_q;
  assign add_count_o       = na_q;
  assign sub_count_o       = ns_q;
  assign iteration_count_o = it_q;

endmodule

FILE: src/restoring_nonrestoring_divider.sv
// an accepted input reaches result valid through WIDTH + 1 register stages
// throughput: one item per cycle unless the output stalls, set by the row of WIDTH cells that each
// perform one shift-and-add/subtract iteration and register it
// every stage stalls only when its own register is full and not drained
// reset clears all stage valid bits and selects restoring division
module restoring_nonrestoring_divider
  import rnd_pkg::*;
#(
  parameter int WIDTH = DefaultWidth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_method_select_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2*WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0]   divisor_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [WIDTH-1:0]   quotient_o,
  output logic [WIDTH-1:0]   remainder_o,
  output logic               overflow_o,
  output logic [CntW-1:0]    add_count_o,
  output logic [CntW-1:0]    sub_count_o,
  output logic [CntW-1:0]    iteration_count_o
);

  method_e          method_q;
  logic             st_valid [WIDTH+1];
  logic             st_ready [WIDTH+1];
  rnd_ctl_t         st_ctl   [WIDTH+1];
  logic [WIDTH+1:0] st_p     [WIDTH+1];
  logic [WIDTH-1:0] st_q     [WIDTH+1];
  logic [WIDTH-1:0] st_b     [WIDTH+1];
  logic [WIDTH-1:0] hi;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q <= METHOD_RESTORING;
    end else if (cfg_valid_i && cfg_ready_o) begin
      method_q <= method_e'(cfg_method_select_i);
    end
  end

  // entry: split dividend and flag overflow, which includes a zero divisor
  assign hi              = dividend_i[2*WIDTH-1:WIDTH];
  assign st_valid[0]     = in_valid_i;
  assign st_ctl[0].method = method_q;
  assign st_ctl[0].ovf   = (hi >= divisor_i);
  assign st_ctl[0].na    = '0;
  assign st_ctl[0].ns    = '0;
  assign st_p[0]         = {2'b00, hi};
  assign st_q[0]         = dividend_i[WIDTH-1:0];
  assign st_b[0]         = divisor_i;
  assign in_ready_o      = st_ready[0];

  for (genvar k = 0; k < WIDTH; k++) begin : g_cell
    rnd_cell #(
      .WIDTH(WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(st_valid[k]),
      .ready_o(st_ready[k]),
      .ctl_i  (st_ctl[k]),
      .p_i    (st_p[k]),
      .q_i    (st_q[k]),
      .b_i    (st_b[k]),
      .valid_o(st_valid[k+1]),
      .ready_i(st_ready[k+1]),
      .ctl_o  (st_ctl[k+1]),
      .p_o    (st_p[k+1]),
      .q_o    (st_q[k+1]),
      .b_o    (st_b[k+1])
    );
  end

  rnd_out #(
    .WIDTH(WIDTH)
  ) u_out (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (st_valid[WIDTH]),
    .ready_o          (st_ready[WIDTH]),
    .ctl_i            (st_ctl[WIDTH]),
    .p_i              (st_p[WIDTH]),
    .q_i              (st_q[WIDTH]),
    .b_i              (st_b[WIDTH]),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .quotient_o       (quotient_o),
    .remainder_o      (remainder_o),
    .overflow_o       (overflow_o),
    .add_count_o      (add_count_o),
    .sub_count_o      (sub_count_o),
    .iteration_count_o(iteration_count_o)
  );

  // restoring: one subtract per iteration; non-restoring: one add or subtract
  // per iteration plus at most one correction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !overflow_o |->
      (sub_count_o == CntW'(WIDTH)) ||
      (({1'b0, add_count_o} + {1'b0, sub_count_o}) == (CntW+1)'(WIDTH)) ||
      (({1'b0, add_count_o} + {1'b0, sub_count_o}) == (CntW+1)'(WIDTH + 1)))
    else $error("add and subtract counts do not match iteration count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |->
      quotient_o == '0 && remainder_o == '0 && iteration_count_o == '0)
    else $error("overflow result not cleared");

  // an item in the last cell must stay put while the output stage is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_valid[WIDTH] && !st_ready[WIDTH] |=> st_valid[WIDTH] && $stable(st_q[WIDTH]))
    else $error("item lost at the end of the cell row");

endmodule

FILE: sim/restoring_nonrestoring_divider_test.sv
module restoring_nonrestoring_divider_test
  import rnd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = DefaultWidth;
  localparam int WatchdogLimit = 2000;
  localparam int HoldCycles = 120;

  typedef struct {
    logic [2*W-1:0] dividend;
    logic [W-1:0]   divisor;
  } div_op_t;

  typedef struct packed {
    logic [W-1:0]    quot;
    logic [W-1:0]    rem;
    logic            ovf;
    logic [CntW-1:0] adds;
    logic [CntW-1:0] subs;
    logic [CntW-1:0] iters;
  } div_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic           cfg_method = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  logic [2*W-1:0] dividend = '0;
  logic [W-1:0]   divisor = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  logic [W-1:0]   quotient;
  logic [W-1:0]   remainder;
  logic           overflow;
  logic [CntW-1:0] add_count;
  logic [CntW-1:0] sub_count;
  logic [CntW-1:0] iteration_count;

  div_op_t  pend_q[$];
  div_res_t division_q[$];
  method_e  method = METHOD_RESTORING;
  logic     in_taken = 1'b0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       stall_req = 0;
  int       stall_seen = 0;
  int       hold_left = 0;
  int       idle_cycles = 0;
  int       errors = 0;

  restoring_nonrestoring_divider #(
    .WIDTH(W)
  ) i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_method_select_i(cfg_method),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .dividend_i         (dividend),
    .divisor_i          (divisor),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .quotient_o         (quotient),
    .remainder_o        (remainder),
    .overflow_o         (overflow),
    .add_count_o        (add_count),
    .sub_count_o        (sub_count),
    .iteration_count_o  (iteration_count)
  );

  always #5 clk_i = ~clk_i;

  function automatic div_res_t divide(input logic [2*W-1:0] dvd, input logic [W-1:0] dvs,
                                      input method_e m);
    div_res_t          r;
    logic [W-1:0]      q;
    logic [W:0]        acc;
    logic signed [W+1:0] p;
    logic              neg;
    r = '0;
    q = dvd[W-1:0];
    if (dvd[2*W-1:W] >= dvs) begin
      r.ovf = 1'b1;
      return r;
    end
    r.iters = CntW'(W);
    if (m == METHOD_RESTORING) begin
      acc = {1'b0, dvd[2*W-1:W]};
      for (int i = 0; i < W; i++) begin
        acc = {acc[W-1:0], q[W-1]};
        q = q << 1;
        r.subs++;
        // negative trial difference is undone by a restore
        if (acc < {1'b0, dvs}) begin
          r.adds++;
        end else begin
          acc = acc - {1'b0, dvs};
          q[0] = 1'b1;
        end
      end
      r.rem = acc[W-1:0];
    end else begin
      p = {2'b00, dvd[2*W-1:W]};
      for (int i = 0; i < W; i++) begin
        neg = p[W+1];
        p = {p[W:0], q[W-1]};
        q = q << 1;
        if (!neg) begin
          p = p - {2'b00, dvs};
          r.subs++;
        end else begin
          p = p + {2'b00, dvs};
          r.adds++;
        end
        if (!p[W+1]) q[0] = 1'b1;
      end
      // negative partial remainder gets one closing correction
      if (p[W+1]) begin
        p = p + {2'b00, dvs};
        r.adds++;
      end
      r.rem = p[W-1:0];
    end
    r.quot = q;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] expv, input logic [31:0] actv);
    if (expv !== actv) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expv, actv);
      errors++;
    end
  endtask

  // driver: a new item goes out only once the previous one was taken
  always @(negedge clk_i) begin : drive
    div_op_t op;
    if (!in_valid || in_taken) begin
      if (pend_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        op = pend_q.pop_front();
        in_valid <= 1'b1;
        dividend <= op.dividend;
        divisor <= op.divisor;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_req != stall_seen) begin
      stall_seen = stall_req;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : monitor
    div_res_t exp_r;
    in_taken <= in_valid && in_ready;
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (cfg_valid && cfg_ready) method = method_e'(cfg_method);
      if (in_valid && in_ready) division_q.push_back(divide(dividend, divisor, method));
      if (out_valid && out_ready) begin
        if (division_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual q=%h r=%h ovf=%b", $time,
                   quotient, remainder, overflow);
          errors++;
        end else begin
          exp_r = division_q.pop_front();
          check_field("quotient", 32'(exp_r.quot), 32'(quotient));
          check_field("remainder", 32'(exp_r.rem), 32'(remainder));
          check_field("overflow", 32'(exp_r.ovf), 32'(overflow));
          check_field("add_count", 32'(exp_r.adds), 32'(add_count));
          check_field("sub_count", 32'(exp_r.subs), 32'(sub_count));
          check_field("iteration_count", 32'(exp_r.iters), 32'(iteration_count));
        end
      end
    end
  end

  initial begin : watchdog
    while (idle_cycles < WatchdogLimit) @(negedge clk_i);
    $display("FAIL");
    $finish;
  end

  task automatic add_op(input logic [2*W-1:0] dvd, input logic [W-1:0] dvs);
    div_op_t op;
    op.dividend = dvd;
    op.divisor = dvs;
    pend_q.push_back(op);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i); while (pend_q.size() != 0 || in_valid || division_q.size() != 0);
  endtask

  task automatic write_method(input method_e m);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_method <= m;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic add_directed();
    add_op(32'h0000_0000, 16'h0001);
    add_op(32'h0000_0000, 16'h0000);   // zero divisor
    add_op(32'hFFFF_FFFF, 16'h0000);
    add_op(32'hFFFF_FFFF, 16'hFFFF);   // upper half equals divisor
    add_op(32'h0000_FFFF, 16'h0001);
    add_op(32'hFFFE_FFFF, 16'hFFFF);   // largest quotient and remainder
    add_op(32'h1234_0000, 16'h1234);
    add_op(32'h1233_FFFF, 16'h1234);
    add_op(32'h0000_0002, 16'h0003);   // ends negative in non-restoring mode
    add_op(32'h0000_0007, 16'h0002);
    add_op(32'h7FFF_8000, 16'h8000);
    add_op(32'h8000_0000, 16'h0001);
  endtask

  task automatic add_random(input int n);
    int          sel;
    int          k;
    logic [W-1:0] b;
    logic [W-1:0] hi;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 8) begin
        // well-formed: divisor of random magnitude, upper half below it
        k = $urandom_range(1, W);
        b = W'($urandom) & W'((1 << k) - 1);
        b[k-1] = 1'b1;
        hi = W'($urandom_range(0, b - 1));
        add_op({hi, W'($urandom)}, b);
      end else if (sel == 8) begin
        add_op($urandom, W'($urandom));
      end else begin
        b = $urandom_range(0, 1) ? '0 : W'($urandom);
        hi = W'($urandom_range(b, (1 << W) - 1));
        add_op({hi, W'($urandom)}, b);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 33;
    recv_idle_pct = 57;
    write_method(METHOD_RESTORING);
    add_directed();
    add_random(200);
    wait_idle();

    send_idle_pct = 57;
    recv_idle_pct = 33;
    write_method(METHOD_NONRESTORING);
    add_directed();
    add_random(200);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_method(METHOD_RESTORING);
    add_random(200);
    // long receiver hold while the sender keeps offering
    stall_req++;
    wait_idle();

    write_method(METHOD_NONRESTORING);
    add_random(200);
    wait_idle();

    repeat (W + 5) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
